// ===== rtl/tcpid_pkg.sv =====
// ---------------------------------------------------------------------------
// Thermo cooler PID package
// Types, limits and fixed-point constants shared by the regulator modules.
// ---------------------------------------------------------------------------
package tcpid_pkg;

    // Accumulator and multiplier widths of the serial multiply-accumulate.
    localparam int ACC_W  = 36;
    localparam int MUL_W  = 16;
    localparam int BIT_W  = 4;

    // Register indexes on the configuration port.
    typedef enum logic [1:0] {
        REG_SETPOINT = 2'd0,
        REG_GAIN_P   = 2'd1,
        REG_GAIN_I   = 2'd2,
        REG_GAIN_D   = 2'd3
    } t_reg_idx;

    // Regulation mode kept between readings.
    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_REG   = 2'd1,
        MODE_FAULT = 2'd2
    } t_mode;

    // Reported status codes.
    typedef enum logic [1:0] {
        STAT_IDLE    = 2'd0,
        STAT_REG     = 2'd1,
        STAT_FAULT   = 2'd2,
        STAT_CLEARED = 2'd3
    } t_status;

    // PID term being accumulated.
    typedef enum logic [1:0] {
        TERM_P = 2'd0,
        TERM_I = 2'd1,
        TERM_D = 2'd2
    } t_term;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_LOAD,
        ST_STEP,
        ST_DRIVE,
        ST_DAC_LOAD,
        ST_DAC_STEP,
        ST_CODE,
        ST_DONE
    } t_state;

    // Control of the serial multiply-accumulate unit.
    typedef struct packed {
        logic load;
        logic clear;
        logic step;
    } t_mac_ctl;

    localparam logic [15:0] SETPOINT_RST = 16'd0;
    localparam logic [15:0] GAIN_P_RST   = 16'd2867;
    localparam logic [15:0] GAIN_I_RST   = 16'd410;
    localparam logic [15:0] GAIN_D_RST   = 16'd0;

    localparam logic signed [17:0] INTEG_LIMIT    = 18'sd30720;
    localparam logic signed [15:0] TEMP_HIGH      = 16'sd9472;
    localparam logic signed [15:0] TEMP_LOW_FAULT = -16'sd1818;
    localparam logic signed [15:0] TEMP_CLEAR     = 16'sd8960;
    localparam logic signed [ACC_W-1:0] OUT_THRESHOLD = -(ACC_W'(3) <<< 20);

    localparam logic [23:0] DRIVE_MAX  = 24'd3994;
    localparam logic [12:0] DAC_OFFSET = 13'd5553;
    localparam logic [MUL_W-1:0] DAC_SCALE = 16'd13030;
    localparam logic [19:0] CODE_MAX   = 20'd1023;
    localparam logic [12:0] DAC_CMD    = 13'h1000;

endpackage

// ===== rtl/tcpid_serial_mac.sv =====
// ---------------------------------------------------------------------------
// Serial multiply-accumulate
// Shift-and-add unit taking one multiplier bit per cycle while stepped.
// ---------------------------------------------------------------------------
module tcpid_serial_mac (
    input  logic                                   i_clk,
    input  tcpid_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [tcpid_pkg::ACC_W-1:0]     i_mcand,
    input  logic        [tcpid_pkg::MUL_W-1:0]     i_mplier,
    output logic signed [tcpid_pkg::ACC_W-1:0]     o_acc
);

    logic signed [tcpid_pkg::ACC_W-1:0] r_mcand, n_mcand;
    logic        [tcpid_pkg::MUL_W-1:0] r_mplier, n_mplier;
    logic signed [tcpid_pkg::ACC_W-1:0] r_acc, n_acc;

    // The multiplicand moves left as the multiplier moves right, so the
    // accumulator only ever adds the multiplicand or nothing.
    always_comb begin
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_acc    = r_acc;
        if (i_ctl.load) begin
            n_mcand  = i_mcand;
            n_mplier = i_mplier;
            if (i_ctl.clear) begin
                n_acc = '0;
            end
        end else if (i_ctl.step) begin
            if (r_mplier[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand  = r_mcand <<< 1;
            n_mplier = r_mplier >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_acc    <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// ===== rtl/thermo_cooler_pid_regulator.sv =====
// ---------------------------------------------------------------------------
// Thermo cooler PID regulator
// Clamped-integral PID on Q8.8 temperature readings driving a cooler DAC.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Contents (lowest bit first)
//  s_*       in         temperature[15:0], enable[16], zero pad to 24 bits
//  m_*       out        cooler_on[0], dac_word[13:1], dac_write[14],
//                       status[16:15], zero pad to 24 bits
//  i_cfg_*   in         write enable, register index (2 bits), data (16 bits)
//
// A reading that ends without a PID step (disabled, fault entry, fault held
// or cleared) goes from evaluation straight to the hand-over state. A PID
// step that drives the cooler runs the three gain products through one
// shift-and-add unit at one gain bit per cycle, and the DAC scaling then
// runs on the same unit; a weak output skips the scaling. The next reading
// is taken once the previous result sits in the output register, even while
// that result still waits for its transfer; if the output register is still
// full when a new result is ready, the regulator waits with it. Reset is
// synchronous and active low; it restores the default gains, a zero
// setpoint, idle mode and an empty output register.
// ---------------------------------------------------------------------------
module thermo_cooler_pid_regulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,     // temperature[15:0], enable[16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // cooler_on[0], dac_word[13:1],
                                     // dac_write[14], status[16:15]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata
);

    // Configuration registers.
    logic [15:0] r_setpoint, r_gain_p, r_gain_i, r_gain_d;

    // Control and regulation state.
    tcpid_pkg::t_state r_state, n_state;
    tcpid_pkg::t_mode  r_mode, n_mode;
    tcpid_pkg::t_term  r_term, n_term;
    logic [tcpid_pkg::BIT_W-1:0] r_bit, n_bit;
    logic signed [15:0] r_integ, n_integ;
    logic signed [16:0] r_prev, n_prev;
    logic               r_m_valid, n_m_valid;

    // Per-reading working registers.
    logic signed [15:0] r_temp, n_temp;
    logic               r_en, n_en;
    logic signed [16:0] r_err, n_err;
    logic signed [15:0] r_sum, n_sum;
    logic signed [17:0] r_derr, n_derr;
    logic [12:0]        r_diff, n_diff;
    logic               r_res_cooler, n_res_cooler;
    logic [12:0]        r_res_word, n_res_word;
    tcpid_pkg::t_status r_res_status, n_res_status;
    logic [23:0]        r_m_data, n_m_data;

    // Serial multiply-accumulate unit.
    tcpid_pkg::t_mac_ctl mac_ctl;
    logic signed [tcpid_pkg::ACC_W-1:0] mac_mcand;
    logic [tcpid_pkg::MUL_W-1:0]        mac_mplier;
    logic signed [tcpid_pkg::ACC_W-1:0] mac_acc;

    tcpid_serial_mac u_mac (
        .i_clk    (i_clk),
        .i_ctl    (mac_ctl),
        .i_mcand  (mac_mcand),
        .i_mplier (mac_mplier),
        .o_acc    (mac_acc)
    );

    // Error, clamped integral and error difference of the current reading.
    logic signed [16:0] err_val;
    logic signed [17:0] sum_wide;
    logic signed [15:0] sum_val;
    logic signed [17:0] derr_val;
    logic               temp_out_of_range;

    assign err_val  = {r_setpoint[15], r_setpoint} - {r_temp[15], r_temp};
    assign sum_wide = {{2{r_integ[15]}}, r_integ} + {err_val[16], err_val};
    assign derr_val = {err_val[16], err_val} - {r_prev[16], r_prev};
    assign temp_out_of_range = (r_temp > tcpid_pkg::TEMP_HIGH) ||
                               (r_temp <= tcpid_pkg::TEMP_LOW_FAULT);

    always_comb begin
        if (sum_wide > tcpid_pkg::INTEG_LIMIT) begin
            sum_val = tcpid_pkg::INTEG_LIMIT[15:0];
        end else if (sum_wide < -tcpid_pkg::INTEG_LIMIT) begin
            sum_val = 16'(-tcpid_pkg::INTEG_LIMIT);
        end else begin
            sum_val = sum_wide[15:0];
        end
    end

    // Drive voltage in Q8.8 from the negated PID output, capped at 15.6 V.
    logic signed [tcpid_pkg::ACC_W-1:0] neg_pid;
    logic [23:0] drive_full;
    logic [11:0] drive_val;
    logic [19:0] code_full;
    logic [9:0]  code_val;

    assign neg_pid    = -mac_acc;
    assign drive_full = neg_pid[35:12];
    assign drive_val  = (drive_full > tcpid_pkg::DRIVE_MAX) ?
                        tcpid_pkg::DRIVE_MAX[11:0] : drive_full[11:0];
    assign code_full  = mac_acc[35:16];
    assign code_val   = (code_full > tcpid_pkg::CODE_MAX) ?
                        tcpid_pkg::CODE_MAX[9:0] : code_full[9:0];

    assign s_tready = (r_state == tcpid_pkg::ST_IDLE);
    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= tcpid_pkg::SETPOINT_RST;
            r_gain_p   <= tcpid_pkg::GAIN_P_RST;
            r_gain_i   <= tcpid_pkg::GAIN_I_RST;
            r_gain_d   <= tcpid_pkg::GAIN_D_RST;
        end else if (i_cfg_we) begin
            unique case (tcpid_pkg::t_reg_idx'(i_cfg_addr))
                tcpid_pkg::REG_SETPOINT: r_setpoint <= i_cfg_wdata;
                tcpid_pkg::REG_GAIN_P:   r_gain_p   <= i_cfg_wdata;
                tcpid_pkg::REG_GAIN_I:   r_gain_i   <= i_cfg_wdata;
                tcpid_pkg::REG_GAIN_D:   r_gain_d   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Next state and datapath control.
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_term       = r_term;
        n_bit        = r_bit;
        n_integ      = r_integ;
        n_prev       = r_prev;
        n_temp       = r_temp;
        n_en         = r_en;
        n_err        = r_err;
        n_sum        = r_sum;
        n_derr       = r_derr;
        n_diff       = r_diff;
        n_res_cooler = r_res_cooler;
        n_res_word   = r_res_word;
        n_res_status = r_res_status;
        n_m_data     = r_m_data;
        n_m_valid    = r_m_valid && !m_tready;
        mac_ctl      = '0;
        mac_mcand    = '0;
        mac_mplier   = '0;

        unique case (r_state)
            tcpid_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    n_temp  = s_tdata[15:0];
                    n_en    = s_tdata[16];
                    n_state = tcpid_pkg::ST_EVAL;
                end
            end

            tcpid_pkg::ST_EVAL: begin
                // Default to a quiet result; only a strong PID output drives.
                n_res_cooler = 1'b0;
                n_res_word   = '0;
                n_state      = tcpid_pkg::ST_DONE;
                if (!r_en) begin
                    n_mode       = tcpid_pkg::MODE_IDLE;
                    n_res_status = tcpid_pkg::STAT_IDLE;
                end else if (r_mode == tcpid_pkg::MODE_FAULT) begin
                    if (r_temp < tcpid_pkg::TEMP_CLEAR) begin
                        n_mode       = tcpid_pkg::MODE_IDLE;
                        n_res_status = tcpid_pkg::STAT_CLEARED;
                    end else begin
                        n_res_status = tcpid_pkg::STAT_FAULT;
                    end
                end else if (temp_out_of_range) begin
                    n_mode       = tcpid_pkg::MODE_FAULT;
                    n_res_status = tcpid_pkg::STAT_FAULT;
                end else begin
                    n_err        = err_val;
                    n_sum        = sum_val;
                    n_derr       = derr_val;
                    n_integ      = sum_val;
                    n_prev       = err_val;
                    n_mode       = tcpid_pkg::MODE_REG;
                    n_res_status = tcpid_pkg::STAT_REG;
                    n_term       = tcpid_pkg::TERM_P;
                    n_state      = tcpid_pkg::ST_LOAD;
                end
            end

            tcpid_pkg::ST_LOAD: begin
                mac_ctl.load  = 1'b1;
                mac_ctl.clear = (r_term == tcpid_pkg::TERM_P);
                case (r_term)
                    tcpid_pkg::TERM_P: begin
                        mac_mcand  = tcpid_pkg::ACC_W'(r_err);
                        mac_mplier = r_gain_p;
                    end
                    tcpid_pkg::TERM_I: begin
                        mac_mcand  = tcpid_pkg::ACC_W'(r_sum);
                        mac_mplier = r_gain_i;
                    end
                    default: begin
                        mac_mcand  = tcpid_pkg::ACC_W'(r_derr);
                        mac_mplier = r_gain_d;
                    end
                endcase
                n_bit   = '0;
                n_state = tcpid_pkg::ST_STEP;
            end

            tcpid_pkg::ST_STEP: begin
                mac_ctl.step = 1'b1;
                n_bit        = r_bit + 1'b1;
                if (r_bit == '1) begin
                    if (r_term == tcpid_pkg::TERM_D) begin
                        n_state = tcpid_pkg::ST_DRIVE;
                    end else begin
                        n_term  = tcpid_pkg::t_term'(r_term + 2'd1);
                        n_state = tcpid_pkg::ST_LOAD;
                    end
                end
            end

            tcpid_pkg::ST_DRIVE: begin
                if (mac_acc < tcpid_pkg::OUT_THRESHOLD) begin
                    n_diff  = tcpid_pkg::DAC_OFFSET - {1'b0, drive_val};
                    n_state = tcpid_pkg::ST_DAC_LOAD;
                end else begin
                    n_state = tcpid_pkg::ST_DONE;
                end
            end

            tcpid_pkg::ST_DAC_LOAD: begin
                mac_ctl.load  = 1'b1;
                mac_ctl.clear = 1'b1;
                mac_mcand     = tcpid_pkg::ACC_W'({1'b0, r_diff});
                mac_mplier    = tcpid_pkg::DAC_SCALE;
                n_bit         = '0;
                n_state       = tcpid_pkg::ST_DAC_STEP;
            end

            tcpid_pkg::ST_DAC_STEP: begin
                mac_ctl.step = 1'b1;
                n_bit        = r_bit + 1'b1;
                if (r_bit == '1) begin
                    n_state = tcpid_pkg::ST_CODE;
                end
            end

            tcpid_pkg::ST_CODE: begin
                n_res_cooler = 1'b1;
                n_res_word   = tcpid_pkg::DAC_CMD + 13'({code_val, 2'b00});
                n_state      = tcpid_pkg::ST_DONE;
            end

            tcpid_pkg::ST_DONE: begin
                // Hand over once the output register is free or being emptied.
                if (!r_m_valid || m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {7'd0, r_res_status, r_res_cooler,
                                 r_res_word, r_res_cooler};
                    n_state   = tcpid_pkg::ST_IDLE;
                end
            end

            default: n_state = tcpid_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tcpid_pkg::ST_IDLE;
            r_mode    <= tcpid_pkg::MODE_IDLE;
            r_integ   <= '0;
            r_prev    <= '0;
            r_m_valid <= 1'b0;
            r_term    <= tcpid_pkg::TERM_P;
            r_bit     <= '0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_integ   <= n_integ;
            r_prev    <= n_prev;
            r_m_valid <= n_m_valid;
            r_term    <= n_term;
            r_bit     <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_temp       <= n_temp;
        r_en         <= n_en;
        r_err        <= n_err;
        r_sum        <= n_sum;
        r_derr       <= n_derr;
        r_diff       <= n_diff;
        r_res_cooler <= n_res_cooler;
        r_res_word   <= n_res_word;
        r_res_status <= n_res_status;
        r_m_data     <= n_m_data;
    end

`ifndef ASSERT_OFF
    // The stored integral never leaves the clamp window.
    a_integ_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_integ <= 16'sd30720) && (r_integ >= -16'sd30720))
        else $error("integral sum outside clamp window");

    // A DAC write is only reported while regulating with the cooler on.
    a_write_regulating: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[14]) |->
            (m_tdata[0] && (m_tdata[16:15] == tcpid_pkg::STAT_REG)))
        else $error("DAC write outside regulation");

    // A driven word always carries the command bit and a whole code.
    a_word_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[14]) |-> (m_tdata[13] && (m_tdata[2:1] == 2'b00)))
        else $error("malformed DAC word");

    // A transfer on the input side starts evaluation in the next cycle.
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> (r_state == tcpid_pkg::ST_EVAL))
        else $error("accepted reading not evaluated");

    // While in fault mode, a finished reading always carries a fault status.
    a_fault_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_mode == tcpid_pkg::MODE_FAULT) && (r_state == tcpid_pkg::ST_DONE)) |->
            (r_res_status == tcpid_pkg::STAT_FAULT))
        else $error("fault mode without fault status");
`endif

endmodule

// ===== tb/tcpid_cmd_checker.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Thermo cooler regulator command checker
// Watches the configuration port and both stream channels of the regulator.
// It keeps its own copy of the registers and the regulation state, works out
// the cooler command that each accepted reading should produce, and compares
// every result transfer field by field with the oldest outstanding command.
// ---------------------------------------------------------------------------
module tcpid_cmd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [23:0] i_s_tdata,     // temperature[15:0], enable[16]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,     // cooler_on[0], dac_word[13:1],
                                       // dac_write[14], status[16:15]
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_driven,
    output int          o_faults
);
    import tcpid_pkg::*;

    localparam logic signed [15:0] HOT_TRIP  = 16'sd9472;    // 37.0 degrees
    localparam logic signed [15:0] COLD_TRIP = -16'sd1818;   // at or below -7.1 degrees
    localparam logic signed [15:0] RECOVER   = 16'sd8960;    // 35.0 degrees
    localparam int     SUM_CLAMP  = 30720;                   // 120 degrees
    localparam longint WEAK_FLOOR = -(longint'(3) <<< 20);   // -3.0 in Q.20
    localparam longint DRIVE_CAP  = 3994;                    // 15.6 V in Q8.8
    localparam longint DAC_BIAS   = 5553;
    localparam longint DAC_GAIN   = 13030;
    localparam longint CODE_CAP   = 1023;
    localparam logic [12:0] DAC_WRITE_CMD = 13'h1000;
    localparam int     MAX_REPORTS = 100;

    typedef struct packed {
        logic        cooler_on;
        logic [12:0] dac_word;
        logic        dac_write;
        t_status     status;
    } t_cooler_cmd;

    logic signed [15:0] setpoint_q8;
    logic [15:0]        kp, ki, kd;
    t_mode              mode;
    logic signed [15:0] err_sum;
    logic signed [16:0] last_err;
    t_cooler_cmd        cooler_cmd_q[$];

    int fails    = 0;
    int reports  = 0;
    int checked  = 0;
    int driven   = 0;
    int faults   = 0;
    int pending  = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending;
    assign o_checked    = checked;
    assign o_driven     = driven;
    assign o_faults     = faults;

    // One regulation step: updates the mode and PID state, returns the command.
    function automatic t_cooler_cmd regulate(input logic signed [15:0] temp, input logic en);
        t_cooler_cmd cmd;
        int          err, sum, derr;
        longint      pid, drive, code;
        cmd = '0;
        if (!en) begin
            mode = MODE_IDLE;
            cmd.status = STAT_IDLE;
        end else if (mode == MODE_FAULT) begin
            if (temp < RECOVER) begin
                mode = MODE_IDLE;
                cmd.status = STAT_CLEARED;
            end else begin
                cmd.status = STAT_FAULT;
            end
        end else if (temp > HOT_TRIP || temp <= COLD_TRIP) begin
            mode = MODE_FAULT;
            cmd.status = STAT_FAULT;
        end else begin
            err = int'(setpoint_q8) - int'(temp);
            sum = int'(err_sum) + err;
            if (sum > SUM_CLAMP)
                sum = SUM_CLAMP;
            else if (sum < -SUM_CLAMP)
                sum = -SUM_CLAMP;
            derr = err - int'(last_err);
            pid = longint'(kp) * err + longint'(ki) * sum + longint'(kd) * derr;
            err_sum  = sum[15:0];
            last_err = err[16:0];
            mode = MODE_REG;
            cmd.status = STAT_REG;
            if (pid < WEAK_FLOOR) begin
                drive = (-pid) >>> 12;
                if (drive > DRIVE_CAP)
                    drive = DRIVE_CAP;
                code = ((DAC_BIAS - drive) * DAC_GAIN) >>> 16;
                if (code > CODE_CAP)
                    code = CODE_CAP;
                cmd.cooler_on = 1'b1;
                cmd.dac_word  = DAC_WRITE_CMD + 13'(code * 4);
                cmd.dac_write = 1'b1;
            end
        end
        return cmd;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            fails++;
            if (reports < MAX_REPORTS) begin
                reports++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_cooler_cmd want, got;
        if (!i_rst_n) begin
            setpoint_q8 = SETPOINT_RST;
            kp = GAIN_P_RST;
            ki = GAIN_I_RST;
            kd = GAIN_D_RST;
            mode = MODE_IDLE;
            err_sum = '0;
            last_err = '0;
            cooler_cmd_q.delete();
        end else begin
            // A result always belongs to an earlier reading, so it is retired
            // before a reading accepted at the same edge is predicted.
            if (i_m_tvalid && i_m_tready) begin
                got.cooler_on = i_m_tdata[0];
                got.dac_word  = i_m_tdata[13:1];
                got.dac_write = i_m_tdata[14];
                got.status    = t_status'(i_m_tdata[16:15]);
                checked++;
                if (cooler_cmd_q.size() == 0) begin
                    fails++;
                    if (reports < MAX_REPORTS) begin
                        reports++;
                        $display("%0t ns: unexpected result, expected none, actual %h",
                                 $time, i_m_tdata);
                    end
                end else begin
                    want = cooler_cmd_q.pop_front();
                    check_field("cooler_on", want.cooler_on, got.cooler_on);
                    check_field("dac_word", want.dac_word, got.dac_word);
                    check_field("dac_write", want.dac_write, got.dac_write);
                    check_field("status", want.status, got.status);
                    if (want.cooler_on)
                        driven++;
                    if (want.status == STAT_FAULT)
                        faults++;
                end
            end
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_addr))
                    REG_SETPOINT: setpoint_q8 = i_cfg_wdata;
                    REG_GAIN_P:   kp = i_cfg_wdata;
                    REG_GAIN_I:   ki = i_cfg_wdata;
                    REG_GAIN_D:   kd = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                cooler_cmd_q.push_back(regulate(i_s_tdata[15:0], i_s_tdata[16]));
        end
        pending = cooler_cmd_q.size();
    end

endmodule

// ===== tb/tb_thermo_cooler_pid_regulator.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Thermo cooler PID regulator testbench
// Drives temperature readings and register writes into the regulator and
// leaves prediction and comparison to the command checker beside it. A short
// directed opening covers the fault thresholds, the idle path, integral
// clamping and the drive threshold; random phases with varied gains follow.
// ---------------------------------------------------------------------------
module tb_thermo_cooler_pid_regulator;
    import tcpid_pkg::*;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata    = '0;
    logic        m_tvalid;
    logic        m_tready   = 1'b0;
    logic [23:0] m_tdata;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_addr = REG_SETPOINT;
    logic [15:0] i_cfg_wdata = '0;

    int fail_count, pending, checked, driven, faults;
    int readings = 0;

    // Pacing controls set by the stimulus for the sender and the result sink.
    bit tx_steady = 1'b0;   // sender offers readings back to back
    bit rx_steady = 1'b0;   // sink accepts every result at once
    bit rx_hold   = 1'b0;   // sink is to hold off for a long stretch

    always #6 i_clk = ~i_clk;

    thermo_cooler_pid_regulator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    tcpid_cmd_checker cmd_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_driven     (driven),
        .o_faults     (faults)
    );

    // Register writes take effect at the edge after the one where they are set
    // up, so two calls in a row never touch the enable in the same step.
    task automatic apply_reg(input t_reg_idx idx, input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic set_gains(input logic [15:0] sp, input logic [15:0] p,
                             input logic [15:0] i, input logic [15:0] d);
        apply_reg(REG_SETPOINT, sp);
        apply_reg(REG_GAIN_P, p);
        apply_reg(REG_GAIN_I, i);
        apply_reg(REG_GAIN_D, d);
    endtask

    // Offers one reading and returns at the edge where its transfer took
    // place. The valid is only lowered when a gap is drawn, so a back-to-back
    // reading never sees valid dropped and raised in the same step.
    task automatic offer_reading(input logic [15:0] temp, input logic en);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, en, temp};
        do @(posedge i_clk); while (!s_tready);
        readings++;
    endtask

    // The sender stands still until every outstanding result has arrived.
    // Every reading produces exactly one result, so the regulator is idle then.
    task automatic await_results();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_setpoint();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 16'h8000;
        else if (r < 30)
            return 16'h7FFF;
        else if (r < 40)
            return 16'($urandom);
        else
            return 16'($urandom_range(0, 11289) - 1817);
    endfunction

    function automatic logic [15:0] pick_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'h0000;
        else if (r < 20)
            return 16'hFFFF;
        else if (r < 50)
            return 16'($urandom_range(0, 8191));
        else
            return 16'($urandom_range(0, 65535));
    endfunction

    // Most readings sit inside the regulation window so that the PID path is
    // exercised; some hug the fault and recovery thresholds, and the rest are
    // arbitrary 16-bit values that mostly trip a fault.
    task automatic pick_reading(output logic [15:0] temp, output logic en);
        int r, base;
        r  = $urandom_range(0, 99);
        en = ($urandom_range(0, 19) != 0);
        if (r < 76) begin
            temp = 16'($urandom_range(0, 11289) - 1817);
        end else if (r < 90) begin
            case ($urandom_range(0, 2))
                0:       base = 9472;
                1:       base = 8960;
                default: base = -1818;
            endcase
            temp = 16'(base + $urandom_range(0, 6) - 3);
        end else begin
            temp = 16'($urandom);
        end
    endtask

    // Result sink: a random stall before each result, no stall at all in
    // steady phases, and one long hold-off counted here when requested.
    initial begin : result_sink
        int stall;
        @(posedge i_clk);
        forever begin
            if (rx_hold) begin
                rx_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            stall = rx_steady ? 0 : $urandom_range(0, 12);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        logic [15:0] temp;
        logic        en;
        int          phase;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset gains and a zero setpoint: idle, regulation, fault entry,
        // fault held, fault cleared and a fault dropped by disabling.
        offer_reading(16'd0, 1'b0);
        offer_reading(16'd0, 1'b1);
        offer_reading(16'd9472, 1'b1);      // hottest reading still regulated
        offer_reading(-16'sd1817, 1'b1);    // coldest reading still regulated
        offer_reading(16'd9473, 1'b1);      // just above 37 degrees: fault
        offer_reading(16'h7FFF, 1'b1);      // fault held
        offer_reading(16'd8960, 1'b1);      // exactly 35 degrees is still held
        offer_reading(16'd8959, 1'b1);      // fault cleared
        offer_reading(-16'sd1818, 1'b1);    // cold fault
        offer_reading(16'h8000, 1'b0);      // disabling drops the fault
        offer_reading(16'h8000, 1'b1);
        offer_reading(16'h8000, 1'b1);      // clears at once
        offer_reading(16'h7FFF, 1'b0);
        repeat (4) offer_reading(16'd9472, 1'b1);   // integral hits its lower clamp
        await_results();

        // Unit proportional gain only: -768 error sits exactly on the drive
        // threshold and stays off, one more count switches the cooler on.
        set_gains(16'h0000, 16'd4096, 16'h0000, 16'h0000);
        offer_reading(16'd768, 1'b1);
        offer_reading(16'd769, 1'b1);
        offer_reading(16'd0, 1'b1);
        await_results();

        // Full-scale gains with the setpoint at both ends, then all gains zero.
        set_gains(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (2) offer_reading(-16'sd1817, 1'b1);   // integral hits its upper clamp
        offer_reading(16'd9472, 1'b1);
        await_results();
        set_gains(16'h8000, 16'hFFFF, 16'h0000, 16'hFFFF);
        offer_reading(16'd9472, 1'b1);
        offer_reading(-16'sd1817, 1'b1);    // large positive derivative term
        await_results();
        set_gains(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        offer_reading(16'd100, 1'b1);
        await_results();

        // Random phases, each under its own register setting. Each phase ends
        // with the sender waiting until every result has come back.
        for (phase = 0; phase < 13; phase++) begin
            case (phase)
                0: set_gains(16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: set_gains(16'h7FFF, 16'h0000, 16'h0000, 16'h0000);
                2: set_gains(SETPOINT_RST, GAIN_P_RST, GAIN_I_RST, GAIN_D_RST);
                default: set_gains(pick_setpoint(), pick_gain(), pick_gain(), pick_gain());
            endcase
            tx_steady = (phase % 4 == 1) || (phase == 5);
            rx_steady = (phase % 4 == 2);
            // The sink stalls for a long stretch while readings keep coming,
            // so the output register fills and the regulator refuses input.
            if (phase == 5)
                rx_hold = 1'b1;
            repeat (100) begin
                pick_reading(temp, en);
                offer_reading(temp, en);
            end
            await_results();
        end

        repeat (20) @(posedge i_clk);
        $display("Run covered %0d readings and %0d compared results over 17 register settings.",
                 readings, checked);
        $display("Cooler was driven in %0d results and a fault was reported in %0d.",
                 driven, faults);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin : watchdog
        #15_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== thermo_cooler_pid_regulator.f =====
rtl/tcpid_pkg.sv
rtl/tcpid_serial_mac.sv
rtl/thermo_cooler_pid_regulator.sv
tb/tcpid_cmd_checker.sv
tb/tb_thermo_cooler_pid_regulator.sv
